// ===== rtl/sba_pkg.sv =====
// Shared constants and types for the size-bucketed slot allocator.
package sba_pkg;

	localparam int SLOT_W        = 12;
	localparam int LEN_W         = 3;
	localparam int CFG_W         = 13;
	localparam int STATUS_W      = 2;
	localparam int DEF_MAX_SLOTS = 4096;
	localparam int DEF_MAX_RUN   = 4;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNRECORDED = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// ===== rtl/sba_if.sv =====
// Request and response channel interfaces for the slot allocator.
interface sba_req_if
	import sba_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [LEN_W-1:0]  run_length;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, req_type, run_length, slot_index, input ready);
	modport sink   (input valid, req_type, run_length, slot_index, output ready);
endinterface

interface sba_rsp_if
	import sba_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   granted_slot;
	logic [STATUS_W-1:0] status;

	modport source (output valid, granted_slot, status, input ready);
	modport sink   (input valid, granted_slot, status, output ready);
endinterface

// ===== rtl/size_bucketed_slot_allocator.sv =====
// Slot allocator with per-length free stacks and a bump pointer.
// The result register loads from EXEC after the request transaction, once the output register is free.
// One request at a time: the stack or size memory is read at acceptance, then updated in EXEC.
// The request side takes a new transaction while a result waits in the output register.
// Reset: size table cleared by a sweep over all MAX_SLOTS entries (4096 by default), ready low.
// Stack depths clear at once; next_free resets to 0 and a cfg write reloads it.
module size_bucketed_slot_allocator
	import sba_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int MAX_RUN   = DEF_MAX_RUN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	sba_req_if.sink          req,
	sba_rsp_if.source        rsp
);

	localparam int AW        = $clog2(MAX_SLOTS);
	localparam int DW        = $clog2(MAX_SLOTS + 1);
	localparam int NF_W      = (DW > CFG_W) ? DW : CFG_W;
	localparam int BW        = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int STK_DEPTH = MAX_RUN * (1 << AW);

	state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [NF_W-1:0]   next_free_q;
	logic [DW-1:0]     depth_q [MAX_RUN];
	logic              req_type_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] slot_q;

	logic [LEN_W-1:0]  size_mem [MAX_SLOTS];
	logic [LEN_W-1:0]  size_rd_q;
	logic [SLOT_W-1:0] stack_mem [STK_DEPTH];
	logic [SLOT_W-1:0] stack_rd_q;

	logic                rsp_valid_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic accept, out_free, commit, clr_done;

	// issue side
	logic [31:0]     len_in_ext, b_in_ext, slot_in_ext;
	logic            len_in_ok;
	logic [BW-1:0]   b_in;
	logic [DW-1:0]   depth_in, depth_in_dec;
	logic            stack_re, size_re;
	logic [BW+AW-1:0] stack_ra;
	logic [AW-1:0]   size_ra;

	// execute side
	logic [31:0]     len_ext, b_a_ext, rec_ext, b_f_ext, slot_ext, nf_ext;
	logic            len_ok, rec_ok, fits;
	logic [BW-1:0]   b_a, b_f;
	logic [DW-1:0]   depth_a, depth_f;
	logic [NF_W:0]   nf_sum;

	logic                res_we;
	logic [SLOT_W-1:0]   res_slot;
	logic [STATUS_W-1:0] res_status;
	logic                depth_we;
	logic [BW-1:0]       depth_wb;
	logic [DW-1:0]       depth_wval;
	logic                alloc_we, push_we;
	logic [BW+AW-1:0]    stack_wa;
	logic                size_we;
	logic [AW-1:0]       size_wa;
	logic [LEN_W-1:0]    size_wd;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign clr_done = (clr_q == AW'(MAX_SLOTS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_EXEC;
			ST_EXEC:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		commit    = (state_q == ST_EXEC) && out_free;
	end

	// read issue at acceptance
	always_comb begin
		len_in_ext   = 32'(req.run_length);
		len_in_ok    = (len_in_ext != 32'd0) && (len_in_ext <= 32'(MAX_RUN));
		b_in_ext     = len_in_ext - 32'd1;
		b_in         = b_in_ext[BW-1:0];
		depth_in     = len_in_ok ? depth_q[b_in] : '0;
		depth_in_dec = depth_in - DW'(1);
		stack_ra     = {b_in, depth_in_dec[AW-1:0]};
		stack_re     = accept && (req.req_type == REQ_ALLOC) && len_in_ok && (depth_in != '0);
		slot_in_ext  = 32'(req.slot_index);
		size_ra      = slot_in_ext[AW-1:0];
		size_re      = accept && (req.req_type == REQ_FREE);
	end

	// decision and update
	always_comb begin
		len_ext  = 32'(len_q);
		len_ok   = (len_ext != 32'd0) && (len_ext <= 32'(MAX_RUN));
		b_a_ext  = len_ext - 32'd1;
		b_a      = b_a_ext[BW-1:0];
		depth_a  = len_ok ? depth_q[b_a] : '0;
		rec_ext  = 32'(size_rd_q);
		rec_ok   = (rec_ext != 32'd0) && (rec_ext <= 32'(MAX_RUN));
		b_f_ext  = rec_ext - 32'd1;
		b_f      = b_f_ext[BW-1:0];
		depth_f  = rec_ok ? depth_q[b_f] : '0;
		slot_ext = 32'(slot_q);
		nf_ext   = 32'(next_free_q);
		nf_sum   = {1'b0, next_free_q} + (NF_W + 1)'(len_q);
		fits     = (nf_sum <= (NF_W + 1)'(MAX_SLOTS));

		res_slot   = '0;
		res_status = STATUS_OK;
		depth_we   = 1'b0;
		depth_wb   = b_a;
		depth_wval = depth_a - DW'(1);
		alloc_we   = 1'b0;
		push_we    = 1'b0;
		stack_wa   = {b_f, depth_f[AW-1:0]};

		if (req_type_q == REQ_ALLOC) begin
			if (len_q == '0) begin
				res_status = STATUS_OK;
			end else if (!len_ok) begin
				res_status = STATUS_TOO_LONG;
			end else if (depth_a != '0) begin
				res_slot = stack_rd_q;
				depth_we = 1'b1;
			end else if (!fits) begin
				res_status = STATUS_FULL;
			end else begin
				res_slot = nf_ext[SLOT_W-1:0];
				alloc_we = 1'b1;
			end
		end else begin
			if (slot_q == '0) begin
				res_status = STATUS_OK;
			end else if (slot_ext >= 32'(MAX_SLOTS) || !rec_ok) begin
				res_status = STATUS_UNRECORDED;
			end else if (32'(depth_f) < 32'(MAX_SLOTS)) begin
				push_we    = 1'b1;
				depth_we   = 1'b1;
				depth_wb   = b_f;
				depth_wval = depth_f + DW'(1);
			end
		end

		res_we = commit;
		if (state_q == ST_CLEAR) begin
			size_we = 1'b1;
			size_wa = clr_q;
			size_wd = '0;
		end else begin
			size_we = commit && alloc_we;
			size_wa = nf_ext[AW-1:0];
			size_wd = len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (size_we) size_mem[size_wa] <= size_wd;
		if (size_re) size_rd_q <= size_mem[size_ra];
	end

	always_ff @(posedge clk) begin
		if (commit && push_we) stack_mem[stack_wa] <= slot_q;
		if (stack_re) stack_rd_q <= stack_mem[stack_ra];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			len_q      <= req.run_length;
			slot_q     <= req.slot_index;
		end
		if (res_we) begin
			rsp_slot_q   <= res_slot;
			rsp_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			next_free_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < MAX_RUN; i++) depth_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				next_free_q <= NF_W'(cfg_wdata);
			end else if (commit && alloc_we) begin
				next_free_q <= nf_sum[NF_W-1:0];
			end
			if (commit && depth_we) depth_q[depth_wb] <= depth_wval;
			if (res_we) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_slot = rsp_slot_q;
	assign rsp.status       = rsp_status_q;

endmodule

// ===== rtl/sba_checker.sv =====
// Port-level assertions for the slot allocator, bound to the top level.
module sba_checker
	import sba_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [SLOT_W-1:0]   rsp_granted_slot,
	input logic [STATUS_W-1:0] rsp_status
);

	// one request in flight: ready drops after every request transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another was in progress");

	// a fresh result is checked against an earlier request transaction
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without a matching request");

	// errors never carry a slot
	a_error_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_granted_slot == '0))
		else $error("nonzero slot on error status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_slot)
			&& $stable(rsp_status))
		else $error("stalled result changed");

endmodule

bind size_bucketed_slot_allocator sba_checker u_sba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted_slot (rsp.granted_slot),
	.rsp_status       (rsp.status)
);
